### hw/rtl/twcd_pkg.sv
// Shared constants, request codes and controller/datapath interface types.
`timescale 1ns / 1ps
package twcd_pkg;

  localparam int TEX_W_LOG2  = 6;
  localparam int TEX_H_LOG2  = 6;
  localparam int REGION_LOG2 = 12;
  localparam int STORE_AW    = 14;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int TEXEL_W     = 24;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 13;

  // Offset sum wide enough for row<<W + column and for the region mask.
  localparam int OFF_W = (TEX_H_LOG2 + TEX_W_LOG2 + 1 > REGION_LOG2) ?
                         (TEX_H_LOG2 + TEX_W_LOG2 + 1) : REGION_LOG2;

  // Step dividend is 2^(TEX_H_LOG2+16): one quotient bit per cycle.
  localparam int DIVW      = TEX_H_LOG2 + 17;
  localparam int DIV_CNT_W = $clog2(DIVW);

  localparam logic [TEXEL_W-1:0] HALF_MASK = 24'd8355711;

  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = 13'd640;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SCREEN_HEIGHT = 1'd1;

  localparam logic [1:0] REQ_SETUP = 2'd0;
  localparam logic [1:0] REQ_TICK  = 2'd1;
  localparam logic [1:0] REQ_LOAD  = 2'd2;

  typedef struct packed {
    logic ld_setup;
    logic mul_en;
    logic div_start;
    logic col_en;
    logic ld_step;
    logic pos_en;
    logic tick_en;
    logic load_en;
    logic out_load;
  } twcd_cmd_t;

  typedef struct packed {
    logic div_busy;
    logic tick_hit;
  } twcd_sts_t;

endpackage

### hw/rtl/twcd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module twcd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/twcd_div.sv
// Restoring divider: 2^(TEX_H_LOG2+16) / divisor, one quotient bit per cycle.
`timescale 1ns / 1ps
module twcd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] divisor,
  output logic        busy,
  output logic [31:0] quotient
);

  logic [15:0]                     rem_r, rem_nxt;
  logic [31:0]                     quo_r, quo_nxt;
  logic [twcd_pkg::DIV_CNT_W-1:0]  cnt_r;
  logic                            busy_r;
  logic [16:0]                     trial;

  always_comb begin
    // Only the leading dividend bit is set.
    trial   = {rem_r, (cnt_r == '0)};
    rem_nxt = rem_r;
    quo_nxt = {quo_r[30:0], 1'b0};
    if (trial >= {1'b0, divisor}) begin
      rem_nxt = 16'(trial - {1'b0, divisor});
      quo_nxt = {quo_r[30:0], 1'b1};
    end else begin
      rem_nxt = trial[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rem_r  <= '0;
      quo_r  <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == twcd_pkg::DIV_CNT_W'(twcd_pkg::DIVW - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy     = busy_r;
  assign quotient = quo_r;

endmodule

### hw/rtl/twcd_ctrl.sv
// Controller: request decode, setup sequencing and output handshake.
`timescale 1ns / 1ps
module twcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [1:0]          in_req_type,
  output logic                out_valid,
  input  logic                out_ready,
  input  twcd_pkg::twcd_sts_t sts,
  output twcd_pkg::twcd_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_COL,
    S_DIV,
    S_POS,
    S_TICK
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   accept;

  assign out_free = !out_valid_r || out_ready;
  assign in_ready = (state_r == S_IDLE) || ((state_r == S_TICK) && out_free);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd           = '0;
    cmd.ld_setup  = accept && (in_req_type == twcd_pkg::REQ_SETUP);
    cmd.tick_en   = accept && (in_req_type == twcd_pkg::REQ_TICK);
    cmd.load_en   = accept && (in_req_type == twcd_pkg::REQ_LOAD);
    cmd.mul_en    = (state_r == S_MUL);
    cmd.div_start = (state_r == S_MUL);
    cmd.col_en    = (state_r == S_COL);
    cmd.ld_step   = (state_r == S_DIV) && !sts.div_busy;
    cmd.pos_en    = (state_r == S_POS);
    cmd.out_load  = (state_r == S_TICK) && out_free;

    state_nxt = state_r;
    case (state_r)
      S_IDLE, S_TICK: begin
        if (state_r == S_TICK && out_free) begin
          state_nxt = S_IDLE;
        end
        if (accept) begin
          case (in_req_type)
            twcd_pkg::REQ_SETUP: state_nxt = S_MUL;
            twcd_pkg::REQ_TICK:  state_nxt = sts.tick_hit ? S_TICK : S_IDLE;
            default:             state_nxt = S_IDLE;
          endcase
        end
      end
      S_MUL:   state_nxt = S_COL;
      S_COL:   state_nxt = S_DIV;
      S_DIV:   state_nxt = sts.div_busy ? S_DIV : S_POS;
      S_POS:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase

    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_no_accept_in_setup: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL || state_r == S_COL || state_r == S_DIV || state_r == S_POS)
      |-> !in_ready)
    else $error("input taken during column setup");

  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_valid_r || out_ready))
    else $error("output register overwritten while full");

  a_div_runs_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MUL) |=> sts.div_busy)
    else $error("divider not running after start");
`endif

endmodule

### hw/rtl/twcd_dp.sv
// Datapath: setup arithmetic, column state, texture store and output register.
`timescale 1ns / 1ps
module twcd_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  twcd_pkg::twcd_cmd_t                    cmd,
  output twcd_pkg::twcd_sts_t                    sts,
  input  logic                                   cfg_we,
  input  logic [twcd_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [twcd_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic [11:0]                            in_column,
  input  logic                                   in_hit_side,
  input  logic                                   in_facing_positive,
  input  logic [31:0]                            in_player_along,
  input  logic signed [17:0]                     in_ray_dir_along,
  input  logic [31:0]                            in_perp_dist,
  input  logic [11:0]                            in_draw_start,
  input  logic [12:0]                            in_draw_end,
  input  logic [15:0]                            in_line_height,
  input  logic [twcd_pkg::STORE_AW-1:0]          in_texel_address,
  input  logic [twcd_pkg::TEXEL_W-1:0]           in_texel_color,
  output logic [23:0]                            out_pixel_address,
  output logic [twcd_pkg::TEXEL_W-1:0]           out_pixel_color,
  output logic                                   out_last_of_column
);

  localparam int TW = twcd_pkg::TEX_W_LOG2;
  localparam int TH = twcd_pkg::TEX_H_LOG2;

  logic [12:0] screen_width_r, screen_height_r;

  // Setup operands
  logic [31:0] perp_r;
  logic [17:0] mag_r;
  logic        neg_r;
  logic [15:0] player_lo_r;
  logic [15:0] lh_r;
  logic [49:0] prod_r;

  // Column state
  logic [1:0]    tex_num_r;
  logic [TW-1:0] tex_col_r;
  logic [31:0]   tex_pos_r;
  logic [31:0]   tex_step_r;
  logic [12:0]   cur_row_r;
  logic [12:0]   end_row_r;
  logic [11:0]   draw_col_r;
  logic          shade_r;
  logic          active_r;

  // Tick pipeline and output register
  logic [23:0] paddr_p_r;
  logic        shade_p_r;
  logic        last_p_r;
  logic [23:0] out_addr_r;
  logic [twcd_pkg::TEXEL_W-1:0] out_color_r;
  logic        out_last_r;

  logic [17:0] ray_bits;
  logic [17:0] mag_in;
  logic [32:0] round_sum;
  logic [15:0] q_lo;
  logic [15:0] frac;
  logic [31:0] base;
  logic        div_busy;
  logic [31:0] div_quo;
  logic [TH-1:0] tex_row;
  logic [twcd_pkg::OFF_W-1:0] off_sum;
  logic [twcd_pkg::STORE_AW-1:0] rd_addr;
  logic [25:0] row_mul;
  logic [26:0] pa_sum;
  logic [13:0] row_inc;
  logic        tick_hit;
  logic        last_now;
  logic [twcd_pkg::TEXEL_W-1:0] rd_data;
  logic [twcd_pkg::TEXEL_W-1:0] color;

  assign ray_bits = $unsigned(in_ray_dir_along);
  assign mag_in   = ray_bits[17] ? 18'(18'd0 - ray_bits) : ray_bits;

  // Negative products round toward minus infinity: negate the ceiling.
  assign round_sum = 33'(prod_r[31:0]) + 33'd65535;
  assign q_lo      = neg_r ? 16'(16'd0 - round_sum[31:16]) : prod_r[31:16];
  assign frac      = 16'(player_lo_r + q_lo);

  assign base = 32'(cur_row_r) - 32'(screen_height_r[12:1]) + 32'(lh_r[15:1]);

  assign tick_hit = active_r && (cur_row_r < end_row_r);
  assign row_inc  = 14'(cur_row_r) + 14'd1;
  assign last_now = row_inc >= 14'(end_row_r);

  assign tex_row = tex_pos_r[16 +: TH];
  assign off_sum = (twcd_pkg::OFF_W'(tex_row) << TW) + twcd_pkg::OFF_W'(tex_col_r);
  assign rd_addr = {tex_num_r, off_sum[twcd_pkg::REGION_LOG2-1:0]};

  assign row_mul = cur_row_r * screen_width_r;
  assign pa_sum  = 27'(row_mul) + 27'(draw_col_r);

  assign color = shade_p_r ? ((rd_data >> 1) & twcd_pkg::HALF_MASK) : rd_data;

  twcd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .divisor  (lh_r),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  twcd_ram #(
    .WIDTH (twcd_pkg::TEXEL_W),
    .DEPTH (twcd_pkg::STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (cmd.load_en),
    .waddr (in_texel_address),
    .wdata (in_texel_color),
    .re    (cmd.tick_en && tick_hit),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      screen_width_r  <= twcd_pkg::SCREEN_WIDTH_RST;
      screen_height_r <= twcd_pkg::SCREEN_HEIGHT_RST;
      active_r        <= 1'b0;
      tex_num_r       <= '0;
      tex_col_r       <= '0;
      tex_pos_r       <= '0;
      tex_step_r      <= '0;
      cur_row_r       <= '0;
      end_row_r       <= '0;
      draw_col_r      <= '0;
      shade_r         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          twcd_pkg::CFG_SCREEN_WIDTH:  screen_width_r  <= cfg_wdata;
          twcd_pkg::CFG_SCREEN_HEIGHT: screen_height_r <= cfg_wdata;
          default: ;
        endcase
      end

      if (cmd.ld_setup) begin
        perp_r      <= in_perp_dist;
        mag_r       <= mag_in;
        neg_r       <= ray_bits[17];
        player_lo_r <= in_player_along[15:0];
        lh_r        <= (in_line_height == 16'd0) ? 16'd1 : in_line_height;
        tex_num_r   <= in_hit_side ? (in_facing_positive ? 2'd3 : 2'd2)
                                   : (in_facing_positive ? 2'd0 : 2'd1);
        cur_row_r   <= 13'(in_draw_start);
        end_row_r   <= in_draw_end;
        draw_col_r  <= in_column;
        shade_r     <= in_hit_side;
        active_r    <= 13'(in_draw_start) < in_draw_end;
      end

      if (cmd.mul_en) begin
        prod_r <= perp_r * mag_r;
      end
      if (cmd.col_en) begin
        tex_col_r <= frac[15 -: TW];
      end
      if (cmd.ld_step) begin
        tex_step_r <= div_quo;
      end
      if (cmd.pos_en) begin
        tex_pos_r <= 32'(base * tex_step_r);
      end

      if (cmd.tick_en) begin
        if (tick_hit) begin
          // Capture the address side now; the texel arrives next cycle.
          paddr_p_r <= pa_sum[23:0];
          shade_p_r <= shade_r;
          last_p_r  <= last_now;
          tex_pos_r <= tex_pos_r + tex_step_r;
          cur_row_r <= row_inc[12:0];
          if (last_now) begin
            active_r <= 1'b0;
          end
        end else begin
          active_r <= 1'b0;
        end
      end

      if (cmd.out_load) begin
        out_addr_r  <= paddr_p_r;
        out_color_r <= color;
        out_last_r  <= last_p_r;
      end
    end
  end

  assign sts.div_busy = div_busy;
  assign sts.tick_hit = tick_hit;

  assign out_pixel_address  = out_addr_r;
  assign out_pixel_color    = out_color_r;
  assign out_last_of_column = out_last_r;

endmodule

### hw/rtl/textured_wall_column_drawer_top.sv
// Top level of the textured wall column drawer: controller plus datapath.
//
//   channel | handshake            | carries
//   in_     | in_valid / in_ready  | setup, pixel tick or texel load request
//   out_    | out_valid / out_ready| framebuffer address, color, last flag
//   cfg_    | cfg_we               | screen_width (0), screen_height (1)
//
// Pixel tick: one per cycle while out_ready is high; its result passes through the
// texture store read register, then the output register. Column setup: multiply,
// texture column, bit-serial step divider, start position. Texel load: a direct
// store write. Reset is synchronous, active low; the texture store is not cleared.
// A stalled output register holds the block at one pending tick.
`timescale 1ns / 1ps
module textured_wall_column_drawer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [1:0]                          in_req_type,
  input  logic [11:0]                         in_column,
  input  logic                                in_hit_side,
  input  logic                                in_facing_positive,
  input  logic [31:0]                         in_player_along,
  input  logic signed [17:0]                  in_ray_dir_along,
  input  logic [31:0]                         in_perp_dist,
  input  logic [11:0]                         in_draw_start,
  input  logic [12:0]                         in_draw_end,
  input  logic [15:0]                         in_line_height,
  input  logic [twcd_pkg::STORE_AW-1:0]       in_texel_address,
  input  logic [twcd_pkg::TEXEL_W-1:0]        in_texel_color,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [23:0]                         out_pixel_address,
  output logic [twcd_pkg::TEXEL_W-1:0]        out_pixel_color,
  output logic                                out_last_of_column,
  input  logic                                cfg_we,
  input  logic [twcd_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [twcd_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

  twcd_pkg::twcd_cmd_t cmd;
  twcd_pkg::twcd_sts_t sts;

  twcd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  twcd_dp u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .sts                (sts),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .in_column          (in_column),
    .in_hit_side        (in_hit_side),
    .in_facing_positive (in_facing_positive),
    .in_player_along    (in_player_along),
    .in_ray_dir_along   (in_ray_dir_along),
    .in_perp_dist       (in_perp_dist),
    .in_draw_start      (in_draw_start),
    .in_draw_end        (in_draw_end),
    .in_line_height     (in_line_height),
    .in_texel_address   (in_texel_address),
    .in_texel_color     (in_texel_color),
    .out_pixel_address  (out_pixel_address),
    .out_pixel_color    (out_pixel_color),
    .out_last_of_column (out_last_of_column)
  );

endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the textured wall column drawer.
`timescale 1ns / 1ps
module testbench;

  localparam int TEX_W_LOG2  = twcd_pkg::TEX_W_LOG2;
  localparam int TEX_H_LOG2  = twcd_pkg::TEX_H_LOG2;
  localparam int REGION_LOG2 = twcd_pkg::REGION_LOG2;
  localparam int STORE_AW    = twcd_pkg::STORE_AW;
  localparam int STORE_DEPTH = twcd_pkg::STORE_DEPTH;
  localparam int TEXEL_W     = twcd_pkg::TEXEL_W;
  localparam int CFG_IDX_W   = twcd_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W  = twcd_pkg::CFG_DATA_W;

  localparam logic [TEXEL_W-1:0]    HALF_MASK         = twcd_pkg::HALF_MASK;
  localparam logic [CFG_DATA_W-1:0] SCREEN_WIDTH_RST  = twcd_pkg::SCREEN_WIDTH_RST;
  localparam logic [CFG_DATA_W-1:0] SCREEN_HEIGHT_RST = twcd_pkg::SCREEN_HEIGHT_RST;
  localparam logic [CFG_IDX_W-1:0]  CFG_SCREEN_WIDTH  = twcd_pkg::CFG_SCREEN_WIDTH;
  localparam logic [CFG_IDX_W-1:0]  CFG_SCREEN_HEIGHT = twcd_pkg::CFG_SCREEN_HEIGHT;

  localparam logic [1:0] REQ_SETUP   = twcd_pkg::REQ_SETUP;
  localparam logic [1:0] REQ_TICK    = twcd_pkg::REQ_TICK;
  localparam logic [1:0] REQ_LOAD    = twcd_pkg::REQ_LOAD;
  localparam logic [1:0] REQ_IGNORED = 2'd3;
  localparam logic [1:0] TEX_NORTH   = 2'd0;
  localparam logic [1:0] TEX_SOUTH   = 2'd1;
  localparam logic [1:0] TEX_EAST    = 2'd2;
  localparam logic [1:0] TEX_WEST    = 2'd3;

  localparam int SETUP_CYCLES = 2 * (TEX_H_LOG2 + 21);
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASE_ITEMS  = 125;
  localparam int DIR_ROWS     = 22;
  localparam int SCREEN_SETS  = 6;

  typedef struct packed {
    logic [1:0]          kind;
    logic [11:0]         column;
    logic                side;
    logic                facing;
    logic [31:0]         player;
    logic [17:0]         ray;
    logic [31:0]         perp;
    logic [11:0]         dstart;
    logic [12:0]         dend;
    logic [15:0]         lheight;
    logic [STORE_AW-1:0] taddr;
    logic [TEXEL_W-1:0]  tcolor;
  } wall_req_t;

  typedef struct packed {
    logic [23:0]        addr;
    logic [TEXEL_W-1:0] color;
    logic               last;
  } pixel_t;

  typedef enum {CHK_MODEL, CHK_NONE, CHK_PIXEL} chk_kind_t;

  typedef struct {
    wall_req_t req;
    chk_kind_t chk;
    pixel_t    pix;
  } script_row_t;

  localparam pixel_t NO_PIXEL = '0;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [1:0]            in_req_type;
  logic [11:0]           in_column;
  logic                  in_hit_side;
  logic                  in_facing_positive;
  logic [31:0]           in_player_along;
  logic [17:0]           in_ray_dir_along;
  logic [31:0]           in_perp_dist;
  logic [11:0]           in_draw_start;
  logic [12:0]           in_draw_end;
  logic [15:0]           in_line_height;
  logic [STORE_AW-1:0]   in_texel_address;
  logic [TEXEL_W-1:0]    in_texel_color;
  logic                  out_valid;
  logic                  out_ready;
  logic [23:0]           out_pixel_address;
  logic [TEXEL_W-1:0]    out_pixel_color;
  logic                  out_last_of_column;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  textured_wall_column_drawer_top dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_req_type        (in_req_type),
    .in_column          (in_column),
    .in_hit_side        (in_hit_side),
    .in_facing_positive (in_facing_positive),
    .in_player_along    (in_player_along),
    .in_ray_dir_along   (in_ray_dir_along),
    .in_perp_dist       (in_perp_dist),
    .in_draw_start      (in_draw_start),
    .in_draw_end        (in_draw_end),
    .in_line_height     (in_line_height),
    .in_texel_address   (in_texel_address),
    .in_texel_color     (in_texel_color),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_pixel_address  (out_pixel_address),
    .out_pixel_color    (out_pixel_color),
    .out_last_of_column (out_last_of_column),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Column drawer state as the block should hold it
  logic [CFG_DATA_W-1:0] scr_w;
  logic [CFG_DATA_W-1:0] scr_h;
  logic [TEXEL_W-1:0]    texels [STORE_DEPTH];
  bit                    texel_loaded [STORE_DEPTH];
  logic [1:0]            tex_num;
  logic [TEX_W_LOG2-1:0] tex_col;
  logic [31:0]           tex_pos;
  logic [31:0]           tex_step;
  logic [12:0]           row_now;
  logic [12:0]           row_end;
  logic [11:0]           col_now;
  bit                    shade;
  bit                    active;

  pixel_t pending_pixels [$];
  int     mismatches = 0;
  int     pixels_seen = 0;
  int     items_sent = 0;
  int     n_setup = 0, n_tick = 0, n_load = 0, n_skip = 0;
  int     burst_left = 0, gap_left = 0;
  bit     valid_on = 1'b0;
  int     hold_req = 0;

  // Store entry the next tick reads; returns whether that tick draws a pixel.
  function automatic bit texel_for_tick(output logic [STORE_AW-1:0] idx);
    logic [TEX_H_LOG2-1:0]  trow;
    logic [REGION_LOG2-1:0] off;
    trow = tex_pos[16 +: TEX_H_LOG2];
    off  = REGION_LOG2'((32'(trow) << TEX_W_LOG2) + 32'(tex_col));
    idx  = {tex_num, off};
    return active && (row_now < row_end);
  endfunction

  task automatic apply_request(input wall_req_t r, output bit made, output pixel_t px);
    logic [63:0]         mag;
    logic [63:0]         prod;
    logic [63:0]         adv;
    logic [15:0]         frac;
    logic [31:0]         lh;
    logic [31:0]         base;
    logic [31:0]         addr32;
    logic [STORE_AW-1:0] idx;
    made = 1'b0;
    px = NO_PIXEL;
    case (r.kind)
      REQ_SETUP: begin
        mag  = r.ray[17] ? (64'h40000 - 64'(r.ray)) : 64'(r.ray);
        prod = 64'(r.perp) * mag;
        // negative products round toward minus infinity
        adv  = r.ray[17] ? -((prod + 64'd65535) >> 16) : (prod >> 16);
        frac = r.player[15:0] + adv[15:0];
        tex_col = frac[15 -: TEX_W_LOG2];
        if (r.side)
          tex_num = r.facing ? TEX_WEST : TEX_EAST;
        else
          tex_num = r.facing ? TEX_NORTH : TEX_SOUTH;
        lh = (r.lheight == 16'd0) ? 32'd1 : 32'(r.lheight);
        tex_step = 32'((64'd1 << (TEX_H_LOG2 + 16)) / 64'(lh));
        base = 32'(r.dstart) - 32'(scr_h >> 1) + (lh >> 1);
        tex_pos = base * tex_step;
        row_now = 13'(r.dstart);
        row_end = r.dend;
        col_now = r.column;
        shade   = r.side;
        active  = (13'(r.dstart) < r.dend);
      end
      REQ_TICK: begin
        if (texel_for_tick(idx)) begin
          px.color = shade ? ((texels[idx] >> 1) & HALF_MASK) : texels[idx];
          px.last  = (14'(row_now) + 14'd1 >= 14'(row_end));
          addr32   = 32'(row_now) * 32'(scr_w) + 32'(col_now);
          px.addr  = addr32[23:0];
          tex_pos  = tex_pos + tex_step;
          row_now  = row_now + 13'd1;
          if (px.last) active = 1'b0;
          made = 1'b1;
        end else begin
          active = 1'b0;
        end
      end
      REQ_LOAD: begin
        texels[r.taddr]       = r.tcolor;
        texel_loaded[r.taddr] = 1'b1;
      end
      default: ;
    endcase
  endtask

  function automatic wall_req_t random_req(input logic [1:0] kind);
    wall_req_t r;
    r.kind    = kind;
    r.column  = 12'($urandom);
    r.side    = 1'($urandom_range(0, 1));
    r.facing  = 1'($urandom_range(0, 1));
    r.player  = $urandom;
    r.ray     = 18'($urandom);
    r.perp    = $urandom_range(0, 1) ? $urandom : ($urandom >> $urandom_range(1, 31));
    r.dstart  = 12'($urandom);
    r.dend    = 13'($urandom_range(0, 4096));
    r.lheight = $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(1, 256));
    r.taddr   = STORE_AW'($urandom);
    r.tcolor  = TEXEL_W'($urandom);
    return r;
  endfunction

  // One transfer on the input channel, then pace the next one.
  task automatic send(input wall_req_t r, input chk_kind_t chk, input pixel_t typed);
    bit     made;
    pixel_t px;
    if (gap_left > 0) repeat (gap_left) @(posedge clk);
    in_valid           <= 1'b1;
    in_req_type        <= r.kind;
    in_column          <= r.column;
    in_hit_side        <= r.side;
    in_facing_positive <= r.facing;
    in_player_along    <= r.player;
    in_ray_dir_along   <= r.ray;
    in_perp_dist       <= r.perp;
    in_draw_start      <= r.dstart;
    in_draw_end        <= r.dend;
    in_line_height     <= r.lheight;
    in_texel_address   <= r.taddr;
    in_texel_color     <= r.tcolor;
    valid_on = 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_request(r, made, px);
    case (r.kind)
      REQ_SETUP: n_setup++;
      REQ_TICK:  n_tick++;
      REQ_LOAD:  n_load++;
      default:   n_skip++;
    endcase
    if (r.kind != REQ_IGNORED) items_sent++;
    if (chk == CHK_PIXEL)
      pending_pixels.push_back(typed);
    else if (chk == CHK_MODEL && made)
      pending_pixels.push_back(px);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
    end else begin
      gap_left = 0;
    end
    if (gap_left > 0) begin
      in_valid <= 1'b0;
      valid_on = 1'b0;
    end
  endtask

  // Load the texel a tick is about to read if it was never written.
  task automatic offer(input wall_req_t r, input chk_kind_t chk = CHK_MODEL,
                       input pixel_t typed = NO_PIXEL);
    logic [STORE_AW-1:0] idx;
    wall_req_t           fill;
    if (r.kind == REQ_TICK && texel_for_tick(idx) && !texel_loaded[idx]) begin
      fill = random_req(REQ_LOAD);
      fill.taddr = idx;
      send(fill, CHK_MODEL, NO_PIXEL);
    end
    send(r, chk, typed);
  endtask

  task automatic drain_and_wait;
    if (valid_on) begin
      in_valid <= 1'b0;
      valid_on = 1'b0;
    end
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (SETUP_CYCLES) @(posedge clk);
    gap_left = 0;
  endtask

  task automatic set_screen(input logic [CFG_DATA_W-1:0] w, input logic [CFG_DATA_W-1:0] h);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SCREEN_WIDTH;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_index <= CFG_SCREEN_HEIGHT;
    cfg_wdata <= h;
    @(posedge clk);
    cfg_we <= 1'b0;
    scr_w = w;
    scr_h = h;
    @(posedge clk);
  endtask

  // Setup with a nonempty span followed by its ticks, sometimes cut short or overrun.
  task automatic random_column;
    wall_req_t r;
    int        len, ds, de, n;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 80) : $urandom_range(1, 12);
    r = random_req(REQ_SETUP);
    if ($urandom_range(0, 7) == 0) r.dstart = 12'(4096 - len);
    ds = r.dstart;
    de = (ds + len > 4096) ? 4096 : ds + len;
    r.dend = 13'(de);
    offer(r);
    if ($urandom_range(0, 4) == 0) offer(random_req(REQ_LOAD));
    case ($urandom_range(0, 6))
      0:       n = $urandom_range(0, de - ds - 1);
      1:       n = de - ds + 1;
      default: n = de - ds;
    endcase
    repeat (n) offer(random_req(REQ_TICK));
  endtask

  // Result checker
  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      pixels_seen++;
      if (pending_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel: addr %0d color %h last %0d",
                   out_pixel_address, out_pixel_color, out_last_of_column);
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_address !== want.addr || out_pixel_color !== want.color ||
            out_last_of_column !== want.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("pixel mismatch: expected addr %0d color %h last %0d, got %0d %h %0d",
                     want.addr, want.color, want.last,
                     out_pixel_address, out_pixel_color, out_last_of_column);
        end
      end
    end
  end

  // Receiver: changing stall patterns, plus a long hold-off on request
  initial begin
    int mode, mode_left, hold_left, hold_seen;
    mode = 0;
    mode_left = 0;
    hold_left = 0;
    hold_seen = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else begin
        case (mode)
          0:       out_ready <= 1'b1;
          1:       out_ready <= 1'($urandom_range(0, 1));
          2:       out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 6) != 0);
        endcase
      end
    end
  end

  initial begin
    #2_000_000;
    $display("testbench failed");
    $finish;
  end

  initial begin
    script_row_t           script [DIR_ROWS];
    logic [CFG_DATA_W-1:0] w_set [SCREEN_SETS];
    logic [CFG_DATA_W-1:0] h_set [SCREEN_SETS];
    wall_req_t             r;
    int                    target, pick;

    script = '{
      '{'{REQ_TICK, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'd0}, CHK_NONE, NO_PIXEL},
      '{'{REQ_IGNORED, 12'hFFF, 1'b1, 1'b1, 32'hFFFFFFFF, 18'h3FFFF, 32'hFFFFFFFF,
          12'hFFF, 13'h1000, 16'hFFFF, 14'h3FFF, 24'hFFFFFF}, CHK_NONE, NO_PIXEL},
      '{'{REQ_LOAD, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'hFFFFFF}, CHK_NONE, NO_PIXEL},
      '{'{REQ_LOAD, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd64, 24'hABCDEF}, CHK_NONE, NO_PIXEL},
      '{'{REQ_LOAD, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd8192, 24'hFFFFFF}, CHK_NONE, NO_PIXEL},
      '{'{REQ_LOAD, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd16383, 24'h000000}, CHK_NONE, NO_PIXEL},
      '{'{REQ_SETUP, 12'd5, 1'b0, 1'b1, 32'd0, 18'd0, 32'd0, 12'd208, 13'd210, 16'd64,
          14'd0, 24'd0}, CHK_NONE, NO_PIXEL},
      '{'{REQ_TICK, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'd0}, CHK_PIXEL, '{24'd133125, 24'hFFFFFF, 1'b0}},
      '{'{REQ_TICK, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'd0}, CHK_PIXEL, '{24'd133765, 24'hABCDEF, 1'b1}},
      '{'{REQ_TICK, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'd0}, CHK_NONE, NO_PIXEL},
      '{'{REQ_SETUP, 12'd4095, 1'b1, 1'b0, 32'd0, 18'd0, 32'd0, 12'd208, 13'd209, 16'd64,
          14'd0, 24'd0}, CHK_NONE, NO_PIXEL},
      '{'{REQ_TICK, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'd0}, CHK_PIXEL, '{24'd137215, 24'h7F7F7F, 1'b1}},
      '{'{REQ_SETUP, 12'd7, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd100, 13'd100, 16'd64,
          14'd0, 24'd0}, CHK_NONE, NO_PIXEL},
      '{'{REQ_TICK, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'd0}, CHK_NONE, NO_PIXEL},
      '{'{REQ_SETUP, 12'd0, 1'b0, 1'b0, 32'hFFFFFFFF, 18'h20000, 32'hFFFFFFFF, 12'd0,
          13'd3, 16'd0, 14'd0, 24'd0}, CHK_MODEL, NO_PIXEL},
      '{'{REQ_TICK, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'd0}, CHK_MODEL, NO_PIXEL},
      '{'{REQ_SETUP, 12'd2048, 1'b1, 1'b1, 32'd0, 18'h1FFFF, 32'h00018000, 12'd4095,
          13'd4096, 16'd65535, 14'd0, 24'd0}, CHK_MODEL, NO_PIXEL},
      '{'{REQ_TICK, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'd0}, CHK_MODEL, NO_PIXEL},
      '{'{REQ_TICK, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'd0}, CHK_NONE, NO_PIXEL},
      '{'{REQ_LOAD, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd12351, 24'h800001}, CHK_NONE, NO_PIXEL},
      '{'{REQ_SETUP, 12'd0, 1'b1, 1'b1, 32'h0000FC00, 18'd0, 32'd0, 12'd208, 13'd209,
          16'd64, 14'd0, 24'd0}, CHK_NONE, NO_PIXEL},
      '{'{REQ_TICK, 12'd0, 1'b0, 1'b0, 32'd0, 18'd0, 32'd0, 12'd0, 13'd0, 16'd0,
          14'd0, 24'd0}, CHK_PIXEL, '{24'd133120, 24'h400000, 1'b1}}
    };
    w_set = '{13'd1, 13'd4096, 13'($urandom_range(1, 4096)), 13'd4096, 13'd1, 13'd640};
    h_set = '{13'd1, 13'd4096, 13'($urandom_range(1, 4096)), 13'd1, 13'd4096, 13'd480};

    rst_n              <= 1'b0;
    in_valid           <= 1'b0;
    in_req_type        <= REQ_SETUP;
    in_column          <= '0;
    in_hit_side        <= 1'b0;
    in_facing_positive <= 1'b0;
    in_player_along    <= '0;
    in_ray_dir_along   <= '0;
    in_perp_dist       <= '0;
    in_draw_start      <= '0;
    in_draw_end        <= '0;
    in_line_height     <= '0;
    in_texel_address   <= '0;
    in_texel_color     <= '0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_SCREEN_WIDTH;
    cfg_wdata          <= '0;

    scr_w    = SCREEN_WIDTH_RST;
    scr_h    = SCREEN_HEIGHT_RST;
    tex_num  = TEX_NORTH;
    tex_col  = '0;
    tex_pos  = '0;
    tex_step = '0;
    row_now  = '0;
    row_end  = '0;
    col_now  = '0;
    shade    = 1'b0;
    active   = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) offer(script[i].req, script[i].chk, script[i].pix);
    drain_and_wait();

    for (int s = 0; s < SCREEN_SETS; s++) begin
      set_screen(w_set[s], h_set[s]);
      if (s == 0) begin
        // stall the output for a long stretch while a tall column keeps coming
        r = random_req(REQ_SETUP);
        r.dstart = 12'd10;
        r.dend   = 13'd70;
        offer(r);
        hold_req++;
        repeat (60) offer(random_req(REQ_TICK));
        drain_and_wait();
      end
      target = items_sent + PHASE_ITEMS;
      while (items_sent < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 70)
          random_column();
        else if (pick < 80)
          offer(random_req(REQ_LOAD));
        else if (pick < 87)
          offer(random_req(REQ_TICK));
        else if (pick < 92)
          offer(random_req(REQ_IGNORED));
        else begin
          offer(random_req(REQ_SETUP));
          repeat ($urandom_range(0, 3)) offer(random_req(REQ_TICK));
        end
      end
      drain_and_wait();
    end

    mismatches += pending_pixels.size();
    $display("covered %0d column setups, %0d pixel ticks, %0d texel loads, %0d ignored requests",
             n_setup, n_tick, n_load, n_skip);
    $display("checked %0d pixels over %0d screen sizes, %0d mismatches",
             pixels_seen, SCREEN_SETS + 1, mismatches);
    if (mismatches == 0)
      $display("testbench passed");
    else
      $display("testbench failed");
    $finish;
  end

endmodule
